// ===== hdl/xoshiro256ss_random_generator_macros.svh =====
// Assertion macros shared by the checker files of the generator.
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_MACROS_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define XSR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("generator check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define XSR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("generator check failed: next-cycle implication");

`endif

// ===== hdl/xsr_pkg.sv =====
// Package with widths, seeding constants and types of the xoshiro256** generator.
`default_nettype none

package xsr_pkg;

	localparam int unsigned RAW_W   = 64;
	localparam int unsigned RANGE_W = 31;
	localparam int unsigned FRAC_W  = 54;
	localparam int unsigned HALF_W  = 32;

	typedef logic [RAW_W-1:0]   word_t;
	typedef logic [RANGE_W-1:0] range_t;
	typedef logic [FRAC_W-1:0]  frac_t;
	typedef logic [HALF_W-1:0]  half_t;

	localparam word_t SEED_RESET = 64'd1;
	localparam word_t SM_GAMMA   = 64'h9e37_79b9_7f4a_7c15;
	localparam word_t SM_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
	localparam word_t SM_MUL_B   = 64'h94d0_49bb_1331_11eb;

	// Partial product step of a 64x64 multiply, low 64 bits kept.
	typedef enum logic [1:0] {
		PART_LL = 2'd0,
		PART_HL = 2'd1,
		PART_LH = 2'd2
	} part_t;

endpackage

`default_nettype wire

// ===== hdl/xoshiro256ss_random_generator.sv =====
// Top level: xoshiro256** generator with splitmix64 seeding and derived outputs.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------
//  request | in_valid, in_stall, index_range           | in  | valid / stall
//  result  | out_valid, out_stall, raw_word,           | out | valid / stall
//          | bounded_index, uniform_fraction           |     |
//  seed    | cfg_valid, cfg_ready, seed_value          | in  | valid / ready
//
// One request per cycle while in_stall is low; a result is offered after its request
// beat loads the input stage and passes multiply-by-5 and rotate, multiply-by-9,
// and the bounded multiply.
// Seeding uses one shared 32x32 multiplier that does each 64-bit splitmix64
// product in three partial steps.
// After arst_n and after each seed write the block holds in_stall high until
// seeding is done. A stalled result holds its stage; earlier stages keep
// filling until each is occupied.
`default_nettype none

module xoshiro256ss_random_generator (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_stall,
	input  wire xsr_pkg::range_t index_range,
	output      logic            out_valid,
	input  wire logic            out_stall,
	output      xsr_pkg::word_t  raw_word,
	output      xsr_pkg::range_t bounded_index,
	output      xsr_pkg::frac_t  uniform_fraction,
	input  wire logic            cfg_valid,
	output      logic            cfg_ready,
	input  wire xsr_pkg::word_t  seed_value
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MIX1,
		ST_MULA,
		ST_MIX2,
		ST_MULB,
		ST_MIX3
	} state_t;

	state_t          state_q;
	logic [1:0]      idx_q;
	xsr_pkg::part_t  part_q;
	xsr_pkg::word_t  sm_q;
	xsr_pkg::word_t  z_q;
	xsr_pkg::word_t  acc_q;
	xsr_pkg::word_t  w_q [4];

	logic            run;
	logic            in_accept;
	logic            cfg_accept;

	// seeding datapath
	xsr_pkg::word_t  sm_next;
	xsr_pkg::word_t  mul_k;
	xsr_pkg::half_t  mul_a;
	xsr_pkg::half_t  mul_b;
	xsr_pkg::word_t  prod;
	xsr_pkg::word_t  acc_next;

	// generator update
	xsr_pkg::word_t  t_sh;
	xsr_pkg::word_t  n0, n1, n2, n3;

	// result pipeline
	logic            v_s1, v_s2, v_s3, v_s4;
	logic            en_s1, en_s2, en_s3, en_s4;
	xsr_pkg::word_t  w1_s1;
	xsr_pkg::range_t range_s1, range_s2, range_s3;
	xsr_pkg::word_t  rot_s2;
	xsr_pkg::word_t  raw_s3;
	xsr_pkg::word_t  raw_s4;
	xsr_pkg::range_t bidx_s4;
	xsr_pkg::frac_t  frac_s4;
	xsr_pkg::word_t  m5;
	xsr_pkg::word_t  m9;
	logic [62:0]     bprod;

	assign run        = (state_q == ST_RUN);
	assign cfg_ready  = run;
	assign cfg_accept = cfg_valid && cfg_ready;

	// A stage loads when it is empty or its contents move on.
	assign en_s4 = !v_s4 || !out_stall;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall  = !(run && en_s1);
	assign in_accept = in_valid && !in_stall;

	// ---------------- seeding ----------------
	assign sm_next = sm_q + xsr_pkg::SM_GAMMA;
	assign mul_k   = (state_q == ST_MULA) ? xsr_pkg::SM_MUL_A : xsr_pkg::SM_MUL_B;

	always_comb begin
		mul_a    = z_q[31:0];
		mul_b    = mul_k[31:0];
		acc_next = acc_q;
		unique case (part_q)
			xsr_pkg::PART_LL: begin
				mul_a = z_q[31:0];
				mul_b = mul_k[31:0];
			end
			xsr_pkg::PART_HL: begin
				mul_a = z_q[63:32];
				mul_b = mul_k[31:0];
			end
			xsr_pkg::PART_LH: begin
				mul_a = z_q[31:0];
				mul_b = mul_k[63:32];
			end
			default: begin
				mul_a = z_q[31:0];
				mul_b = mul_k[31:0];
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
		// Cross terms only reach the upper half of the low 64 bits.
		if (part_q == xsr_pkg::PART_LL) begin
			acc_next = prod;
		end else begin
			acc_next = acc_q + {prod[31:0], 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_MIX1;
			idx_q   <= 2'd0;
			part_q  <= xsr_pkg::PART_LL;
			sm_q    <= xsr_pkg::SEED_RESET;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (cfg_accept) begin
						sm_q    <= seed_value;
						idx_q   <= 2'd0;
						state_q <= ST_MIX1;
					end
				end
				ST_MIX1: begin
					sm_q    <= sm_next;
					part_q  <= xsr_pkg::PART_LL;
					state_q <= ST_MULA;
				end
				ST_MULA, ST_MULB: begin
					unique case (part_q)
						xsr_pkg::PART_LL: part_q <= xsr_pkg::PART_HL;
						xsr_pkg::PART_HL: part_q <= xsr_pkg::PART_LH;
						default: begin
							part_q  <= xsr_pkg::PART_LL;
							state_q <= (state_q == ST_MULA) ? ST_MIX2 : ST_MIX3;
						end
					endcase
				end
				ST_MIX2: begin
					state_q <= ST_MULB;
				end
				ST_MIX3: begin
					if (idx_q == 2'd3) begin
						state_q <= ST_RUN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= ST_MIX1;
					end
				end
				default: begin
					state_q <= ST_MIX1;
				end
			endcase
		end
	end

	// generator update operands, then the splitmix64 steps and the generator words
	assign t_sh = {w_q[1][46:0], 17'd0};
	assign n2   = w_q[2] ^ w_q[0];
	assign n3   = w_q[3] ^ w_q[1];
	assign n1   = w_q[1] ^ n2;
	assign n0   = w_q[0] ^ n3;

	always_ff @(posedge clk) begin
		if (state_q == ST_MIX1) begin
			z_q <= sm_next ^ (sm_next >> 30);
		end else if (state_q == ST_MIX2) begin
			z_q <= acc_q ^ (acc_q >> 27);
		end
		if (state_q == ST_MULA || state_q == ST_MULB) begin
			acc_q <= acc_next;
		end
		if (state_q == ST_MIX3) begin
			w_q[idx_q] <= acc_q ^ (acc_q >> 31);
		end else if (in_accept) begin
			// advance the generator one step
			w_q[0] <= n0;
			w_q[1] <= n1;
			w_q[2] <= n2 ^ t_sh;
			w_q[3] <= {n3[18:0], n3[63:19]};
		end
	end

	// ---------------- result pipeline ----------------
	assign m5    = w1_s1 + {w1_s1[61:0], 2'd0};
	assign m9    = rot_s2 + {rot_s2[60:0], 3'd0};
	assign bprod = 63'(raw_s3[31:0]) * 63'(range_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_accept;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_accept) begin
			w1_s1    <= w_q[1];
			range_s1 <= index_range;
		end
		if (en_s2 && v_s1) begin
			rot_s2   <= {m5[56:0], m5[63:57]};
			range_s2 <= range_s1;
		end
		if (en_s3 && v_s2) begin
			raw_s3   <= m9;
			range_s3 <= range_s2;
		end
		if (en_s4 && v_s3) begin
			raw_s4  <= raw_s3;
			bidx_s4 <= bprod[62:32];
			frac_s4 <= {raw_s3[63:11], 1'b1};
		end
	end

	assign out_valid        = v_s4;
	assign raw_word         = raw_s4;
	assign bounded_index    = bidx_s4;
	assign uniform_fraction = frac_s4;

endmodule

`default_nettype wire

// ===== hdl/xsr_checker.sv =====
// Port-level checker for the xoshiro256** generator, bound to the top level.
`default_nettype none

`include "xoshiro256ss_random_generator_macros.svh"

module xsr_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_stall,
	input wire logic            out_valid,
	input wire logic            out_stall,
	input wire xsr_pkg::word_t  raw_word,
	input wire xsr_pkg::range_t bounded_index,
	input wire xsr_pkg::frac_t  uniform_fraction,
	input wire logic            cfg_valid,
	input wire logic            cfg_ready
);

	logic cfg_beat;
	logic out_held;
	logic frac_ok;
	logic idle_beats;

	assign cfg_beat   = cfg_valid && cfg_ready;
	assign out_held   = out_valid && out_stall;
	assign frac_ok    = uniform_fraction[0] && (uniform_fraction[53:1] == raw_word[63:11]);
	// no request beat and no seed beat in the same cycle
	assign idle_beats = !(cfg_beat && in_valid && !in_stall);

	// hold a stalled result beat
	`XSR_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(raw_word) && $stable(bounded_index))
	`XSR_ASSERT_IMP(a_frac_raw, out_valid, frac_ok)
	// a seed beat starts seeding, which blocks requests
	`XSR_ASSERT_NXT(a_seed_blocks, cfg_beat, in_stall && !cfg_ready)
	`XSR_ASSERT_IMP(a_one_beat, cfg_valid || in_valid, idle_beats)

endmodule

bind xoshiro256ss_random_generator xsr_checker u_xsr_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the xoshiro256** generator with splitmix64 seeding.
`timescale 1ns / 100ps

module testbench;

	localparam int PHASES       = 8;
	localparam int PHASE_DRAWS  = 100;
	localparam int LONG_HOLD    = 60;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic {
		ROW_DRAW = 1'b0,
		ROW_SEED = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t       kind;
		xsr_pkg::word_t  value;
		logic            pinned;
		xsr_pkg::range_t pinned_index;
	} plan_row_t;

	typedef struct {
		xsr_pkg::word_t  raw;
		xsr_pkg::range_t index;
		xsr_pkg::frac_t  frac;
		logic            pinned;
		xsr_pkg::range_t pinned_index;
	} draw_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	xsr_pkg::range_t index_range;
	logic            out_valid;
	logic            out_stall;
	xsr_pkg::word_t  raw_word;
	xsr_pkg::range_t bounded_index;
	xsr_pkg::frac_t  uniform_fraction;
	logic            cfg_valid;
	logic            cfg_ready;
	xsr_pkg::word_t  seed_value;

	// generator words of the predictor
	xsr_pkg::word_t gen_words [4];
	draw_t pending_draws [$];

	int  fail_count;
	int  draws_checked;
	int  draws_sent;
	int  seeds_written;
	bit  idling_on;
	bit  hold_req;

	// zero range, unit range, both halves of the range bits, all seed extremes
	plan_row_t directed_plan [21] = '{
		'{ROW_DRAW, 64'd1,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'd0,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'h7fff_ffff,          1'b0, 31'd0},
		'{ROW_DRAW, 64'd2,                  1'b0, 31'd0},
		'{ROW_DRAW, 64'h4000_0000,          1'b0, 31'd0},
		'{ROW_DRAW, 64'h5555_5555,          1'b0, 31'd0},
		'{ROW_DRAW, 64'h2aaa_aaaa,          1'b0, 31'd0},
		'{ROW_SEED, 64'd0,                  1'b0, 31'd0},
		'{ROW_DRAW, 64'd0,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'd1,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'h7fff_ffff,          1'b0, 31'd0},
		'{ROW_SEED, 64'hffff_ffff_ffff_ffff, 1'b0, 31'd0},
		'{ROW_DRAW, 64'h7fff_ffff,          1'b0, 31'd0},
		'{ROW_DRAW, 64'd1,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'd3,                  1'b0, 31'd0},
		'{ROW_SEED, 64'd1,                  1'b0, 31'd0},
		'{ROW_DRAW, 64'd1,                  1'b1, 31'd0},
		'{ROW_DRAW, 64'h7fff_ffff,          1'b0, 31'd0},
		'{ROW_SEED, 64'h8000_0000_0000_0000, 1'b0, 31'd0},
		'{ROW_DRAW, 64'd1000,               1'b0, 31'd0},
		'{ROW_DRAW, 64'd0,                  1'b1, 31'd0}
	};

	xoshiro256ss_random_generator DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.index_range      (index_range),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.raw_word         (raw_word),
		.bounded_index    (bounded_index),
		.uniform_fraction (uniform_fraction),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.seed_value       (seed_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// four splitmix64 rounds fill the generator words
	function automatic void expand_seed(xsr_pkg::word_t seed);
		xsr_pkg::word_t z;
		for (int i = 0; i < 4; i++) begin
			seed = seed + xsr_pkg::SM_GAMMA;
			z = seed;
			z = (z ^ (z >> 30)) * xsr_pkg::SM_MUL_A;
			z = (z ^ (z >> 27)) * xsr_pkg::SM_MUL_B;
			gen_words[i] = z ^ (z >> 31);
		end
	endfunction

	function automatic draw_t advance_generator(xsr_pkg::range_t span);
		draw_t          d;
		xsr_pkg::word_t times5;
		xsr_pkg::word_t shifted;
		logic [63:0]    scaled;
		times5 = gen_words[1] * 64'd5;
		d.raw = {times5[56:0], times5[63:57]} * 64'd9;
		shifted = gen_words[1] << 17;
		gen_words[2] = gen_words[2] ^ gen_words[0];
		gen_words[3] = gen_words[3] ^ gen_words[1];
		gen_words[1] = gen_words[1] ^ gen_words[2];
		gen_words[0] = gen_words[0] ^ gen_words[3];
		gen_words[2] = gen_words[2] ^ shifted;
		gen_words[3] = {gen_words[3][18:0], gen_words[3][63:19]};
		scaled = d.raw[31:0] * span;
		d.index = scaled[62:32];
		d.frac = {d.raw[63:11], 1'b1};
		d.pinned = 1'b0;
		d.pinned_index = '0;
		return d;
	endfunction

	function automatic xsr_pkg::range_t pick_span();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return xsr_pkg::range_t'($urandom_range(1, 16));
			5: return xsr_pkg::range_t'($urandom_range(1, 1000));
			default: return xsr_pkg::range_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, xsr_pkg::word_t got, xsr_pkg::word_t want);
		$display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	// one request beat; returns just after the falling edge that follows acceptance
	task automatic send_draw(xsr_pkg::range_t span, logic pinned,
			xsr_pkg::range_t pinned_index);
		draw_t d;
		int    gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		index_range = span;
		do @(posedge clk); while (in_stall);
		d = advance_generator(span);
		d.pinned = pinned;
		d.pinned_index = pinned_index;
		pending_draws = {pending_draws, d};
		draws_sent++;
		@(negedge clk);
	endtask

	task automatic write_seed(xsr_pkg::word_t seed);
		in_valid = 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		seed_value = seed;
		do @(posedge clk); while (!cfg_ready);
		expand_seed(seed);
		seeds_written++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stall bursts, plus one long hold on request
	initial begin : receiver
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				burst = $urandom_range(1, 13);
				repeat (burst) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		draw_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("unexpected result beat", raw_word, '0);
			end else begin
				want = pending_draws.pop_front();
				draws_checked++;
				if (raw_word !== want.raw)
					report_mismatch("raw_word", raw_word, want.raw);
				if (bounded_index !== want.index)
					report_mismatch("bounded_index", xsr_pkg::word_t'(bounded_index),
						xsr_pkg::word_t'(want.index));
				if (uniform_fraction !== want.frac)
					report_mismatch("uniform_fraction", xsr_pkg::word_t'(uniform_fraction),
						xsr_pkg::word_t'(want.frac));
				if (want.pinned && bounded_index !== want.pinned_index)
					report_mismatch("bounded_index (fixed)", xsr_pkg::word_t'(bounded_index),
						xsr_pkg::word_t'(want.pinned_index));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d results pending",
					quiet, pending_draws.size());
				$display("xoshiro256ss_random_generator regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		xsr_pkg::word_t seed;
		arst_n = 1'b0;
		in_valid = 1'b0;
		index_range = '0;
		cfg_valid = 1'b0;
		seed_value = '0;
		hold_req = 1'b0;
		idling_on = 1'b1;
		fail_count = 0;
		draws_checked = 0;
		draws_sent = 0;
		seeds_written = 0;
		expand_seed(xsr_pkg::SEED_RESET);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_SEED)
				write_seed(directed_plan[i].value);
			else
				send_draw(xsr_pkg::range_t'(directed_plan[i].value), directed_plan[i].pinned,
					directed_plan[i].pinned_index);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				3: seed = '1;
				5: seed = '0;
				default: seed = {$urandom, $urandom};
			endcase
			write_seed(seed);
			// last phase runs back to back on both sides
			idling_on = (ph != PHASES - 1);
			// fill the pipeline against a held output
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_DRAWS; n++)
				send_draw(pick_span(), 1'b0, '0);
		end

		in_valid = 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d requests over %0d seed writes, %0d results checked",
			draws_sent, seeds_written, draws_checked);
		$display("included zero and full ranges, seeds 0, 1, all ones, one long output hold");
		if (fail_count == 0)
			$display("xoshiro256ss_random_generator regression: pass");
		else
			$display("xoshiro256ss_random_generator regression: fail");
		$finish;
	end

endmodule
